@@ design/script_tokenizer_unit_assert.svh @@
// Assertion macros used by the script tokenizer top level.
`ifndef SCRIPT_TOKENIZER_UNIT_ASSERT_SVH
`define SCRIPT_TOKENIZER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Clocked check with an asynchronous active-low reset and a fixed report.
`define STU_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("script_tokenizer_unit: internal check failed");
// Same check with a caller-supplied report string.
`define STU_ASSERT_MSG(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);
`else
`define STU_ASSERT(label, clk, rst_n, prop)
`define STU_ASSERT_MSG(label, clk, rst_n, prop, msg)
`endif
`endif

@@ design/stu_pkg.sv @@
// Types, constants and helper functions of the script tokenizer.
`timescale 1ns / 1ps
package stu_pkg;

	localparam int IDENT_MAX  = 23;
	localparam int STRING_MAX = 255;
	localparam int LINE_BITS  = 16;
	localparam int QDEPTH     = 4;

	localparam int WLEN_MAX  = (IDENT_MAX > STRING_MAX) ? IDENT_MAX : STRING_MAX;
	localparam int WLEN_BITS = $clog2(WLEN_MAX + 1);
	localparam int QPTR_BITS = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_BITS = $clog2(QDEPTH + 1);

	localparam int KIND_W = 6;
	localparam int VAL_W  = 32;
	localparam int BYTE_W = 8;
	localparam int LINE_W = 16;
	localparam int ERR_W  = 3;
	localparam int TDATA_W = 64;

	// Token kinds.
	localparam logic [KIND_W-1:0] K_EOF   = 6'd0;
	localparam logic [KIND_W-1:0] K_NUM   = 6'd1;
	localparam logic [KIND_W-1:0] K_STR   = 6'd2;
	localparam logic [KIND_W-1:0] K_IDENT = 6'd3;
	localparam logic [KIND_W-1:0] K_LPAR  = 6'd4;
	localparam logic [KIND_W-1:0] K_RPAR  = 6'd5;
	localparam logic [KIND_W-1:0] K_LBRC  = 6'd6;
	localparam logic [KIND_W-1:0] K_RBRC  = 6'd7;
	localparam logic [KIND_W-1:0] K_SEMI  = 6'd8;
	localparam logic [KIND_W-1:0] K_COMMA = 6'd9;
	localparam logic [KIND_W-1:0] K_PLUS  = 6'd10;
	localparam logic [KIND_W-1:0] K_MINUS = 6'd11;
	localparam logic [KIND_W-1:0] K_STAR  = 6'd12;
	localparam logic [KIND_W-1:0] K_SLASH = 6'd13;
	localparam logic [KIND_W-1:0] K_PCT   = 6'd14;
	localparam logic [KIND_W-1:0] K_CARET = 6'd15;
	localparam logic [KIND_W-1:0] K_ASSIGN = 6'd16;
	localparam logic [KIND_W-1:0] K_EQ    = 6'd17;
	localparam logic [KIND_W-1:0] K_NE    = 6'd18;
	localparam logic [KIND_W-1:0] K_LT    = 6'd19;
	localparam logic [KIND_W-1:0] K_LE    = 6'd20;
	localparam logic [KIND_W-1:0] K_GT    = 6'd21;
	localparam logic [KIND_W-1:0] K_GE    = 6'd22;
	localparam logic [KIND_W-1:0] K_AND   = 6'd23;
	localparam logic [KIND_W-1:0] K_OR    = 6'd24;
	localparam logic [KIND_W-1:0] K_NOT   = 6'd25;
	localparam logic [KIND_W-1:0] K_IF    = 6'd26;
	localparam logic [KIND_W-1:0] K_ELSE  = 6'd27;
	localparam logic [KIND_W-1:0] K_WHILE = 6'd28;
	localparam logic [KIND_W-1:0] K_FUNC  = 6'd29;
	localparam logic [KIND_W-1:0] K_RET   = 6'd30;
	localparam logic [KIND_W-1:0] K_TRUE  = 6'd31;
	localparam logic [KIND_W-1:0] K_FALSE = 6'd32;
	localparam logic [KIND_W-1:0] K_TEXT  = 6'd33;
	localparam logic [KIND_W-1:0] K_ERR   = 6'd34;

	// Error codes.
	localparam logic [ERR_W-1:0] E_NONE   = 3'd0;
	localparam logic [ERR_W-1:0] E_UNTERM = 3'd1;
	localparam logic [ERR_W-1:0] E_AMP    = 3'd2;
	localparam logic [ERR_W-1:0] E_BAR    = 3'd3;
	localparam logic [ERR_W-1:0] E_BADCH  = 3'd4;

	// Characters.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_n     = 8'h6E;
	localparam logic [7:0] CH_t     = 8'h74;
	localparam logic [7:0] CH_BAR   = 8'h7C;

	// Keywords packed with the first character in the lowest byte.
	localparam logic [63:0] KW_IF    = 64'h0000_0000_0000_6669;
	localparam logic [63:0] KW_ELSE  = 64'h0000_0000_6573_6C65;
	localparam logic [63:0] KW_WHILE = 64'h0000_0065_6C69_6877;
	localparam logic [63:0] KW_FUNC  = 64'h6E6F_6974_636E_7566;
	localparam logic [63:0] KW_RET   = 64'h0000_6E72_7574_6572;
	localparam logic [63:0] KW_TRUE  = 64'h0000_0000_6575_7274;
	localparam logic [63:0] KW_FALSE = 64'h0000_0065_736C_6166;

	typedef enum logic [7:0] {
		M_IDLE    = 8'b0000_0001,
		M_NUM     = 8'b0000_0010,
		M_IDENT   = 8'b0000_0100,
		M_STR     = 8'b0000_1000,
		M_ESC     = 8'b0001_0000,
		M_COMMENT = 8'b0010_0000,
		M_HELD    = 8'b0100_0000,
		M_DROP    = 8'b1000_0000
	} mode_t;

	typedef struct packed {
		logic [KIND_W-1:0]        kind;
		logic signed [VAL_W-1:0]  value;
		logic [BYTE_W-1:0]        text_byte;
		logic [ERR_W-1:0]         error_code;
	} res_t;

	// One queue entry: the one or two results caused by one character.
	typedef struct packed {
		res_t              r0;
		res_t              r1;
		logic [LINE_W-1:0] line;
		logic              two;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic res_t mk_res(input logic [KIND_W-1:0] kind,
			input logic signed [VAL_W-1:0] value, input logic [BYTE_W-1:0] text_byte,
			input logic [ERR_W-1:0] error_code);
		res_t r;
		r.kind = kind;
		r.value = value;
		r.text_byte = text_byte;
		r.error_code = error_code;
		return r;
	endfunction

	function automatic logic digit_char(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic letter_char(input logic [7:0] c);
		return (c == 8'h5F) || ((c >= 8'h61) && (c <= 8'h7A)) ||
			((c >= 8'h41) && (c <= 8'h5A));
	endfunction

	// Returns {valid, kind} for single-character operators.
	function automatic logic [KIND_W:0] single_kind(input logic [7:0] c);
		logic [KIND_W:0] r;
		unique case (c)
			8'h28: r = {1'b1, K_LPAR};
			8'h29: r = {1'b1, K_RPAR};
			8'h7B: r = {1'b1, K_LBRC};
			8'h7D: r = {1'b1, K_RBRC};
			8'h3B: r = {1'b1, K_SEMI};
			8'h2C: r = {1'b1, K_COMMA};
			8'h2B: r = {1'b1, K_PLUS};
			8'h2D: r = {1'b1, K_MINUS};
			8'h2A: r = {1'b1, K_STAR};
			8'h25: r = {1'b1, K_PCT};
			8'h5E: r = {1'b1, K_CARET};
			default: r = {1'b0, K_EOF};
		endcase
		return r;
	endfunction

	function automatic logic is_holdable(input logic [7:0] c);
		return (c == CH_EQ) || (c == CH_BANG) || (c == CH_LT) || (c == CH_GT) ||
			(c == CH_AMP) || (c == CH_BAR) || (c == CH_SLASH);
	endfunction

	// Kind of a held character that turned out to stand alone.
	function automatic logic [KIND_W-1:0] held_alone(input logic [7:0] h);
		logic [KIND_W-1:0] k;
		unique case (h)
			CH_EQ:   k = K_ASSIGN;
			CH_BANG: k = K_NOT;
			CH_LT:   k = K_LT;
			CH_GT:   k = K_GT;
			default: k = K_SLASH;
		endcase
		return k;
	endfunction

	function automatic logic [KIND_W-1:0] ident_kind(input logic [WLEN_BITS-1:0] len,
			input logic [63:0] kbuf);
		logic [KIND_W-1:0] k;
		priority if (len == WLEN_BITS'(2) && kbuf == KW_IF) k = K_IF;
		else if (len == WLEN_BITS'(4) && kbuf == KW_ELSE) k = K_ELSE;
		else if (len == WLEN_BITS'(5) && kbuf == KW_WHILE) k = K_WHILE;
		else if (len == WLEN_BITS'(8) && kbuf == KW_FUNC) k = K_FUNC;
		else if (len == WLEN_BITS'(6) && kbuf == KW_RET) k = K_RET;
		else if (len == WLEN_BITS'(4) && kbuf == KW_TRUE) k = K_TRUE;
		else if (len == WLEN_BITS'(5) && kbuf == KW_FALSE) k = K_FALSE;
		else k = K_IDENT;
		return k;
	endfunction

endpackage

@@ design/stu_front.sv @@
// Front end: scans one character per transfer and forms the results it causes.
`timescale 1ns / 1ps
module stu_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  logic [7:0]           ch,
	output logic                 push,
	output stu_pkg::entry_t      wdata
);

	stu_pkg::mode_t                   mode_q, mode_d;
	logic [31:0]                      acc_q, acc_d;
	logic [stu_pkg::WLEN_BITS-1:0]    wlen_q, wlen_d;
	logic [63:0]                      kbuf_q, kbuf_d;
	logic [7:0]                       held_q, held_d;
	logic [stu_pkg::LINE_BITS-1:0]    line_q, line_d;

	// Outcome of treating ch as the start of a new token.
	logic            idle_v;
	stu_pkg::res_t   idle_r;
	stu_pkg::mode_t  idle_mode;
	logic            idle_restart, idle_line_inc, idle_num, idle_ident, idle_str, idle_held;
	logic [stu_pkg::KIND_W:0] sk;

	// Result of the current mode, possibly followed by the idle outcome.
	logic            p_v, do_idle;
	stu_pkg::res_t   p_r;
	logic [7:0]      esc_ch;
	logic [63:0]     kbuf_ins;

	always_comb begin
		sk = stu_pkg::single_kind(ch);
		idle_v = 1'b0;
		idle_r = stu_pkg::mk_res(stu_pkg::K_EOF, '0, '0, stu_pkg::E_NONE);
		idle_mode = stu_pkg::M_IDLE;
		idle_restart = 1'b0;
		idle_line_inc = 1'b0;
		idle_num = 1'b0;
		idle_ident = 1'b0;
		idle_str = 1'b0;
		idle_held = 1'b0;
		priority if (ch == stu_pkg::CH_NUL) begin
			idle_v = 1'b1;
			idle_restart = 1'b1;
		end else if (ch == stu_pkg::CH_LF) begin
			idle_line_inc = 1'b1;
		end else if (ch == stu_pkg::CH_SPACE || ch == stu_pkg::CH_TAB ||
				ch == stu_pkg::CH_CR) begin
			idle_mode = stu_pkg::M_IDLE;
		end else if (stu_pkg::digit_char(ch)) begin
			idle_mode = stu_pkg::M_NUM;
			idle_num = 1'b1;
		end else if (stu_pkg::letter_char(ch)) begin
			idle_mode = stu_pkg::M_IDENT;
			idle_ident = 1'b1;
			idle_v = 1'b1;
			idle_r = stu_pkg::mk_res(stu_pkg::K_TEXT, '0, ch, stu_pkg::E_NONE);
		end else if (ch == stu_pkg::CH_QUOTE) begin
			idle_mode = stu_pkg::M_STR;
			idle_str = 1'b1;
		end else if (sk[stu_pkg::KIND_W]) begin
			idle_v = 1'b1;
			idle_r = stu_pkg::mk_res(sk[stu_pkg::KIND_W-1:0], '0, '0, stu_pkg::E_NONE);
		end else if (stu_pkg::is_holdable(ch)) begin
			idle_mode = stu_pkg::M_HELD;
			idle_held = 1'b1;
		end else begin
			// Unknown character; a zero byte never reaches this arm.
			idle_v = 1'b1;
			idle_r = stu_pkg::mk_res(stu_pkg::K_ERR, '0, '0, stu_pkg::E_BADCH);
			idle_mode = stu_pkg::M_DROP;
		end
	end

	always_comb begin
		esc_ch = ch;
		if (ch == stu_pkg::CH_n) esc_ch = stu_pkg::CH_LF;
		else if (ch == stu_pkg::CH_t) esc_ch = stu_pkg::CH_TAB;
	end

	always_comb begin
		kbuf_ins = kbuf_q;
		for (int i = 0; i < 8; i++) begin
			if (wlen_q < stu_pkg::WLEN_BITS'(8) && wlen_q[2:0] == 3'(i))
				kbuf_ins[8*i +: 8] = ch;
		end
	end

	always_comb begin
		mode_d = mode_q;
		acc_d = acc_q;
		wlen_d = wlen_q;
		kbuf_d = kbuf_q;
		held_d = held_q;
		line_d = line_q;
		p_v = 1'b0;
		p_r = stu_pkg::mk_res(stu_pkg::K_EOF, '0, '0, stu_pkg::E_NONE);
		do_idle = 1'b0;

		unique case (mode_q)
			stu_pkg::M_DROP: begin
				if (ch == stu_pkg::CH_NUL) begin
					mode_d = stu_pkg::M_IDLE;
					acc_d = '0;
					wlen_d = '0;
					kbuf_d = '0;
					held_d = '0;
					line_d = stu_pkg::LINE_BITS'(1);
				end
			end
			stu_pkg::M_STR: begin
				priority if ((wlen_q >= stu_pkg::WLEN_BITS'(stu_pkg::STRING_MAX) &&
						ch != stu_pkg::CH_QUOTE) || ch == stu_pkg::CH_NUL) begin
					p_v = 1'b1;
					p_r = stu_pkg::mk_res(stu_pkg::K_ERR, '0, '0, stu_pkg::E_UNTERM);
					mode_d = stu_pkg::M_DROP;
					if (ch == stu_pkg::CH_NUL) begin
						mode_d = stu_pkg::M_IDLE;
						acc_d = '0;
						wlen_d = '0;
						kbuf_d = '0;
						held_d = '0;
						line_d = stu_pkg::LINE_BITS'(1);
					end
				end else if (ch == stu_pkg::CH_QUOTE) begin
					p_v = 1'b1;
					p_r = stu_pkg::mk_res(stu_pkg::K_STR, stu_pkg::VAL_W'(wlen_q), '0,
						stu_pkg::E_NONE);
					mode_d = stu_pkg::M_IDLE;
					wlen_d = '0;
				end else if (ch == stu_pkg::CH_BSL) begin
					mode_d = stu_pkg::M_ESC;
				end else begin
					p_v = 1'b1;
					p_r = stu_pkg::mk_res(stu_pkg::K_TEXT, '0, ch, stu_pkg::E_NONE);
					wlen_d = wlen_q + 1'b1;
				end
			end
			stu_pkg::M_ESC: begin
				if (ch == stu_pkg::CH_NUL) begin
					p_v = 1'b1;
					p_r = stu_pkg::mk_res(stu_pkg::K_ERR, '0, '0, stu_pkg::E_UNTERM);
					mode_d = stu_pkg::M_IDLE;
					acc_d = '0;
					wlen_d = '0;
					kbuf_d = '0;
					held_d = '0;
					line_d = stu_pkg::LINE_BITS'(1);
				end else begin
					p_v = 1'b1;
					p_r = stu_pkg::mk_res(stu_pkg::K_TEXT, '0, esc_ch, stu_pkg::E_NONE);
					wlen_d = wlen_q + 1'b1;
					mode_d = stu_pkg::M_STR;
				end
			end
			stu_pkg::M_COMMENT: begin
				if (ch == stu_pkg::CH_LF || ch == stu_pkg::CH_NUL) begin
					mode_d = stu_pkg::M_IDLE;
					do_idle = 1'b1;
				end
			end
			stu_pkg::M_NUM: begin
				if (stu_pkg::digit_char(ch)) begin
					acc_d = (acc_q << 3) + (acc_q << 1) + 32'(ch - stu_pkg::CH_ZERO);
				end else begin
					p_v = 1'b1;
					p_r = stu_pkg::mk_res(stu_pkg::K_NUM, acc_q, '0, stu_pkg::E_NONE);
					mode_d = stu_pkg::M_IDLE;
					acc_d = '0;
					do_idle = 1'b1;
				end
			end
			stu_pkg::M_IDENT: begin
				if (stu_pkg::letter_char(ch) || stu_pkg::digit_char(ch)) begin
					if (wlen_q < stu_pkg::WLEN_BITS'(stu_pkg::IDENT_MAX)) begin
						kbuf_d = kbuf_ins;
						wlen_d = wlen_q + 1'b1;
						p_v = 1'b1;
						p_r = stu_pkg::mk_res(stu_pkg::K_TEXT, '0, ch, stu_pkg::E_NONE);
					end
				end else begin
					p_v = 1'b1;
					p_r = stu_pkg::mk_res(stu_pkg::ident_kind(wlen_q, kbuf_q), '0, '0,
						stu_pkg::E_NONE);
					mode_d = stu_pkg::M_IDLE;
					wlen_d = '0;
					kbuf_d = '0;
					do_idle = 1'b1;
				end
			end
			stu_pkg::M_HELD: begin
				held_d = '0;
				mode_d = stu_pkg::M_IDLE;
				priority if (ch == stu_pkg::CH_EQ && (held_q == stu_pkg::CH_EQ ||
						held_q == stu_pkg::CH_BANG || held_q == stu_pkg::CH_LT ||
						held_q == stu_pkg::CH_GT)) begin
					p_v = 1'b1;
					p_r = stu_pkg::mk_res((held_q == stu_pkg::CH_EQ) ? stu_pkg::K_EQ :
						(held_q == stu_pkg::CH_BANG) ? stu_pkg::K_NE :
						(held_q == stu_pkg::CH_LT) ? stu_pkg::K_LE : stu_pkg::K_GE,
						'0, '0, stu_pkg::E_NONE);
				end else if (held_q == stu_pkg::CH_AMP || held_q == stu_pkg::CH_BAR) begin
					p_v = 1'b1;
					if (ch == held_q) begin
						p_r = stu_pkg::mk_res((held_q == stu_pkg::CH_AMP) ? stu_pkg::K_AND :
							stu_pkg::K_OR, '0, '0, stu_pkg::E_NONE);
					end else begin
						p_r = stu_pkg::mk_res(stu_pkg::K_ERR, '0, '0,
							(held_q == stu_pkg::CH_AMP) ? stu_pkg::E_AMP : stu_pkg::E_BAR);
						mode_d = stu_pkg::M_DROP;
						if (ch == stu_pkg::CH_NUL) begin
							mode_d = stu_pkg::M_IDLE;
							acc_d = '0;
							wlen_d = '0;
							kbuf_d = '0;
							line_d = stu_pkg::LINE_BITS'(1);
						end
					end
				end else if (held_q == stu_pkg::CH_SLASH && ch == stu_pkg::CH_SLASH) begin
					mode_d = stu_pkg::M_COMMENT;
				end else begin
					p_v = 1'b1;
					p_r = stu_pkg::mk_res(stu_pkg::held_alone(held_q), '0, '0,
						stu_pkg::E_NONE);
					do_idle = 1'b1;
				end
			end
			default: begin
				do_idle = 1'b1;
			end
		endcase

		if (do_idle) begin
			mode_d = idle_mode;
			if (idle_restart) begin
				acc_d = '0;
				wlen_d = '0;
				kbuf_d = '0;
				held_d = '0;
				line_d = stu_pkg::LINE_BITS'(1);
			end
			if (idle_line_inc && line_q != '1) line_d = line_q + 1'b1;
			if (idle_num) acc_d = 32'(ch - stu_pkg::CH_ZERO);
			if (idle_ident) begin
				kbuf_d = 64'(ch);
				wlen_d = stu_pkg::WLEN_BITS'(1);
			end
			if (idle_str) wlen_d = '0;
			if (idle_held) held_d = ch;
		end
	end

	// The line number seen by both results is the one before this character.
	always_comb begin
		wdata.r0 = p_v ? p_r : idle_r;
		wdata.r1 = idle_r;
		wdata.two = p_v && do_idle && idle_v;
		wdata.line = stu_pkg::LINE_W'(line_q);
		push = take && (p_v || (do_idle && idle_v));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= stu_pkg::M_IDLE;
			acc_q <= '0;
			wlen_q <= '0;
			kbuf_q <= '0;
			held_q <= '0;
			line_q <= stu_pkg::LINE_BITS'(1);
		end else if (take) begin
			mode_q <= mode_d;
			acc_q <= acc_d;
			wlen_q <= wlen_d;
			kbuf_q <= kbuf_d;
			held_q <= held_d;
			line_q <= line_d;
		end
	end

endmodule

@@ design/stu_fifo.sv @@
// Short queue of result entries between the front end and the output stage.
`timescale 1ns / 1ps
module stu_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  stu_pkg::entry_t      wdata,
	input  logic                 pop,
	output stu_pkg::entry_t      rdata,
	output stu_pkg::q_stat_t     stat
);

	stu_pkg::entry_t                 mem_q [stu_pkg::QDEPTH];
	logic [stu_pkg::QPTR_BITS-1:0]   wptr_q, rptr_q;
	logic [stu_pkg::QCNT_BITS-1:0]   cnt_q;

	assign stat.full  = (cnt_q == stu_pkg::QCNT_BITS'(stu_pkg::QDEPTH));
	assign stat.empty = (cnt_q == '0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == stu_pkg::QPTR_BITS'(stu_pkg::QDEPTH - 1)) ? '0 :
					wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == stu_pkg::QPTR_BITS'(stu_pkg::QDEPTH - 1)) ? '0 :
					rptr_q + 1'b1;
			end
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

@@ design/stu_back.sv @@
// Output stage: sends the one or two results of each queue entry in order.
`timescale 1ns / 1ps
module stu_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  stu_pkg::entry_t      rdata,
	input  stu_pkg::q_stat_t     stat,
	output logic                 pop,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [stu_pkg::TDATA_W-1:0] m_tdata,
	output logic [stu_pkg::KIND_W-1:0]  m_tuser,
	output logic                 m_tlast
);

	stu_pkg::entry_t  cur_q;
	logic             valid_q, sel_q;
	stu_pkg::res_t    res;
	logic             fire, done;

	assign res = sel_q ? cur_q.r1 : cur_q.r0;
	assign fire = valid_q && m_tready;
	assign done = fire && m_tlast;
	assign pop = !stat.empty && (!valid_q || done);

	assign m_tvalid = valid_q;
	assign m_tlast = sel_q || !cur_q.two;
	assign m_tuser = res.kind;
	assign m_tdata = stu_pkg::TDATA_W'({res.error_code, cur_q.line, res.text_byte, res.value});

	always_ff @(posedge clk) begin
		if (pop) cur_q <= rdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
			sel_q <= 1'b0;
		end else if (done) begin
			valid_q <= 1'b0;
			sel_q <= 1'b0;
		end else if (fire) begin
			sel_q <= 1'b1;
		end
	end

endmodule

@@ design/script_tokenizer_unit.sv @@
// Top level of the streaming script tokenizer.
`timescale 1ns / 1ps
// Usage: source characters arrive on the slave stream, one per transfer, in
// s_tdata[7:0]; a zero byte ends the source. Tokens leave on the master stream:
// m_tuser carries the token kind and m_tdata the value, text byte, line number
// and error code. m_tlast marks the final result caused by one character.
// The front end scans one character per cycle while the queue has room, and
// writes the one or two results it causes as a single entry into a four-entry
// queue. The output stage drains that queue at one result per cycle while
// the receiver is ready, so a character causing two results holds the output
// for both; sustained throughput is one character per cycle when each causes
// at most one result, set by the single output port. An accepted character's
// results pass through the queue and the output stage register before they
// show on m_tvalid. When the receiver stalls, results wait in the output
// stage and the queue, and s_tready falls only once the queue is full, so
// input keeps flowing while a result waits. Reset clears the scanner state to
// idle between tokens with line one and empties the queue and the output stage.
`include "script_tokenizer_unit_assert.svh"
module script_tokenizer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] ch
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [31:0] value, [39:32] text_byte, [55:40] line,
	                               // [58:56] error_code, [63:59] zero
	output logic [5:0]  m_tuser,   // [5:0] kind
	output logic        m_tlast    // last result of this character
);

	logic               take, push, pop;
	stu_pkg::entry_t    wdata, rdata;
	stu_pkg::q_stat_t   q_stat;

	// A transfer is taken whenever the queue has room for its results.
	assign s_tready = !q_stat.full;
	assign take = s_tvalid && s_tready;

	stu_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.ch     (s_tdata),
		.push   (push),
		.wdata  (wdata)
	);

	stu_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wdata),
		.pop    (pop),
		.rdata  (rdata),
		.stat   (q_stat)
	);

	stu_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rdata    (rdata),
		.stat     (q_stat),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// The front end never writes an entry into a full queue.
	`STU_ASSERT(a_no_push_full, clk, arst_n, push |-> !q_stat.full)
	// The output stage never reads an empty queue.
	`STU_ASSERT(a_no_pop_empty, clk, arst_n, pop |-> !q_stat.empty)
	// With nothing queued, the final result of an entry leaves the output empty.
	`STU_ASSERT_MSG(a_drain_idle, clk, arst_n,
		(m_tvalid && m_tready && m_tlast && q_stat.empty) |=> !m_tvalid,
		"script_tokenizer_unit: output stage did not drain")

endmodule

@@ bench/script_tokenizer_checker.sv @@
// Checker that predicts the token stream of the script tokenizer and compares it.
`timescale 1ns / 1ps
module script_tokenizer_checker
	import stu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,
	input  logic [5:0]  m_tuser,
	input  logic        m_tlast,
	output int          mismatches,
	output int          pending,
	output int          ignored
);

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [31:0]       value;
		logic [7:0]        text_byte;
		logic [15:0]       line;
		logic [ERR_W-1:0]  err;
		logic              last;
	} token_t;

	localparam longint unsigned LINE_TOP = (64'd1 << LINE_BITS) - 1;

	// Scanner state as the block should hold it.
	mode_t           scan_mode;
	logic [31:0]     num_acc;
	int unsigned     word_len;
	logic [63:0]     kw_buf;
	logic [7:0]      held_ch;
	longint unsigned line_no;

	token_t step_toks[$];
	token_t tokens_due[$];
	int     fail_total;
	int     dropped;

	function automatic logic digit_ch(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic letter_ch(input logic [7:0] c);
		return c == "_" || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	// A keyword packed the way the scanner keeps the first bytes of a word.
	function automatic logic [63:0] word_bits(input string w);
		logic [63:0] v;
		int i;
		v = '0;
		for (i = 0; i < w.len() && i < 8; i++)
			v[8*i +: 8] = w[i];
		return v;
	endfunction

	task automatic put(input logic [KIND_W-1:0] k, input logic [31:0] v,
			input logic [7:0] b, input logic [ERR_W-1:0] e);
		token_t t;
		if (step_toks.size() < 2) begin
			t.kind = k;
			t.value = v;
			t.text_byte = b;
			t.line = line_no[15:0];
			t.err = e;
			t.last = 1'b0;
			step_toks.push_back(t);
		end
	endtask

	task automatic restart_scan();
		scan_mode = M_IDLE;
		num_acc = '0;
		word_len = 0;
		kw_buf = '0;
		held_ch = '0;
		line_no = 1;
	endtask

	task automatic raise_error(input logic [ERR_W-1:0] e, input logic [7:0] ch);
		put(K_ERR, '0, '0, e);
		if (ch == CH_NUL)
			restart_scan();
		else
			scan_mode = M_DROP;
	endtask

	task automatic between_tokens(input logic [7:0] ch);
		logic [KIND_W-1:0] k;
		case (ch)
			"(": k = K_LPAR;
			")": k = K_RPAR;
			"{": k = K_LBRC;
			"}": k = K_RBRC;
			";": k = K_SEMI;
			",": k = K_COMMA;
			"+": k = K_PLUS;
			"-": k = K_MINUS;
			"*": k = K_STAR;
			"%": k = K_PCT;
			"^": k = K_CARET;
			default: k = K_EOF;
		endcase
		if (ch == CH_NUL) begin
			put(K_EOF, '0, '0, E_NONE);
			restart_scan();
		end else if (ch == CH_LF) begin
			if (line_no < LINE_TOP)
				line_no++;
		end else if (ch == CH_SPACE || ch == CH_TAB || ch == CH_CR) begin
		end else if (digit_ch(ch)) begin
			scan_mode = M_NUM;
			num_acc = {24'd0, ch - CH_ZERO};
		end else if (letter_ch(ch)) begin
			scan_mode = M_IDENT;
			kw_buf = {56'd0, ch};
			word_len = 1;
			put(K_TEXT, '0, ch, E_NONE);
		end else if (ch == CH_QUOTE) begin
			scan_mode = M_STR;
			word_len = 0;
		end else if (k != K_EOF) begin
			put(k, '0, '0, E_NONE);
		end else if (ch == CH_EQ || ch == CH_BANG || ch == CH_LT || ch == CH_GT ||
				ch == CH_AMP || ch == CH_BAR || ch == CH_SLASH) begin
			scan_mode = M_HELD;
			held_ch = ch;
		end else begin
			raise_error(E_BADCH, ch);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		token_t            t;
		logic [7:0]        ch;
		logic [7:0]        h;
		logic [KIND_W-1:0] k;
		logic              bad;
		if (!arst_n) begin
			restart_scan();
			tokens_due.delete();
			fail_total = 0;
			dropped = 0;
			mismatches <= 0;
			pending <= 0;
			ignored <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				ch = s_tdata;
				step_toks.delete();
				case (scan_mode)
					M_DROP: begin
						dropped++;
						if (ch == CH_NUL)
							restart_scan();
					end
					M_STR: begin
						if (word_len >= STRING_MAX && ch != CH_QUOTE) begin
							raise_error(E_UNTERM, ch);
						end else if (ch == CH_NUL) begin
							raise_error(E_UNTERM, ch);
						end else if (ch == CH_QUOTE) begin
							put(K_STR, 32'(word_len), '0, E_NONE);
							scan_mode = M_IDLE;
							word_len = 0;
						end else if (ch == CH_BSL) begin
							scan_mode = M_ESC;
						end else begin
							put(K_TEXT, '0, ch, E_NONE);
							word_len++;
						end
					end
					M_ESC: begin
						if (ch == CH_NUL) begin
							raise_error(E_UNTERM, ch);
						end else begin
							if (ch == CH_n)
								ch = CH_LF;
							else if (ch == CH_t)
								ch = CH_TAB;
							put(K_TEXT, '0, ch, E_NONE);
							word_len++;
							scan_mode = M_STR;
						end
					end
					M_COMMENT: begin
						if (ch == CH_LF || ch == CH_NUL) begin
							scan_mode = M_IDLE;
							between_tokens(ch);
						end
					end
					M_NUM: begin
						if (digit_ch(ch)) begin
							num_acc = num_acc * 32'd10 + {24'd0, ch - CH_ZERO};
						end else begin
							put(K_NUM, num_acc, '0, E_NONE);
							scan_mode = M_IDLE;
							num_acc = '0;
							between_tokens(ch);
						end
					end
					M_IDENT: begin
						if (letter_ch(ch) || digit_ch(ch)) begin
							if (word_len < IDENT_MAX) begin
								if (word_len < 8)
									kw_buf[8*word_len +: 8] = ch;
								word_len++;
								put(K_TEXT, '0, ch, E_NONE);
							end
						end else begin
							// The word length and the kept bytes decide whether the word is a keyword.
							k = K_IDENT;
							case (word_len)
								2: if (kw_buf == word_bits("if")) k = K_IF;
								4: begin
									if (kw_buf == word_bits("else"))
										k = K_ELSE;
									else if (kw_buf == word_bits("true"))
										k = K_TRUE;
								end
								5: begin
									if (kw_buf == word_bits("while"))
										k = K_WHILE;
									else if (kw_buf == word_bits("false"))
										k = K_FALSE;
								end
								6: if (kw_buf == word_bits("return")) k = K_RET;
								8: if (kw_buf == word_bits("function")) k = K_FUNC;
								default: ;
							endcase
							put(k, '0, '0, E_NONE);
							scan_mode = M_IDLE;
							word_len = 0;
							kw_buf = '0;
							between_tokens(ch);
						end
					end
					M_HELD: begin
						h = held_ch;
						held_ch = '0;
						scan_mode = M_IDLE;
						if (ch == CH_EQ && (h == CH_EQ || h == CH_BANG || h == CH_LT ||
								h == CH_GT)) begin
							put(h == CH_EQ ? K_EQ : h == CH_BANG ? K_NE :
								h == CH_LT ? K_LE : K_GE, '0, '0, E_NONE);
						end else if (h == CH_AMP) begin
							if (ch == CH_AMP)
								put(K_AND, '0, '0, E_NONE);
							else
								raise_error(E_AMP, ch);
						end else if (h == CH_BAR) begin
							if (ch == CH_BAR)
								put(K_OR, '0, '0, E_NONE);
							else
								raise_error(E_BAR, ch);
						end else if (h == CH_SLASH && ch == CH_SLASH) begin
							scan_mode = M_COMMENT;
						end else begin
							put(h == CH_EQ ? K_ASSIGN : h == CH_BANG ? K_NOT :
								h == CH_LT ? K_LT : h == CH_GT ? K_GT : K_SLASH,
								'0, '0, E_NONE);
							between_tokens(ch);
						end
					end
					default: begin
						scan_mode = M_IDLE;
						between_tokens(ch);
					end
				endcase
				if (step_toks.size() > 0)
					step_toks[step_toks.size() - 1].last = 1'b1;
				foreach (step_toks[i])
					tokens_due.push_back(step_toks[i]);
			end

			if (m_tvalid && m_tready) begin
				if (tokens_due.size() == 0) begin
					fail_total++;
					if (fail_total <= 10)
						$display("%0t: token with none expected: kind %0d data %016h last %0b",
							$realtime, m_tuser, m_tdata, m_tlast);
				end else begin
					t = tokens_due.pop_front();
					bad = m_tuser != t.kind || m_tdata[31:0] != t.value ||
						m_tdata[39:32] != t.text_byte || m_tdata[55:40] != t.line ||
						m_tdata[58:56] != t.err || m_tdata[63:59] != 5'd0 ||
						m_tlast != t.last;
					if (bad) begin
						fail_total++;
						if (fail_total <= 10)
							$display({"%0t: token mismatch, expected kind %0d value %0d ",
								"byte %02h line %0d err %0d last %0b; got kind %0d value %0d ",
								"byte %02h line %0d err %0d last %0b pad %02h"},
								$realtime, t.kind, $signed(t.value), t.text_byte, t.line,
								t.err, t.last, m_tuser, $signed(m_tdata[31:0]),
								m_tdata[39:32], m_tdata[55:40], m_tdata[58:56], m_tlast,
								m_tdata[63:59]);
					end
				end
			end

			mismatches <= fail_total;
			pending <= tokens_due.size();
			ignored <= dropped;
		end
	end

endmodule

@@ bench/tb_script_tokenizer_unit.sv @@
// Testbench top that feeds source text to the script tokenizer and gives the verdict.
`timescale 1ns / 1ps
module tb_script_tokenizer_unit;
	import stu_pkg::*;

	// Characters that must reach the scanner in the random part, not counting
	// the ones it throws away after an error.
	localparam int RANDOM_ITEMS = 850;
	// Cycles without any transfer before the run is declared hung. The longest
	// legal quiet stretch is the receiver hold-off plus one sender gap.
	localparam int STALL_LIMIT  = 3000;
	localparam int HOLD_CYCLES  = 400;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic [5:0]  m_tuser;
	logic        m_tlast;

	int mismatches;
	int pending;
	int ignored;

	logic [7:0] src[$];
	int burst_left = 0;
	int fed = 0;
	int idle_cycles = 0;
	int hold_req = 0;

	// Receiver state, private to the receiver process.
	int hold_seen = 0;
	int hold_left = 0;
	int pat_mode = 0;
	int pat_left = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	script_tokenizer_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	script_tokenizer_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.mismatches (mismatches),
		.pending    (pending),
		.ignored    (ignored)
	);

	// The receiver walks through stall patterns of random length: always
	// ready, mostly ready, mostly stalled, and toggling every cycle. A request
	// from the stimulus holds it off completely for HOLD_CYCLES so that the
	// internal queue fills and the block has to drop s_tready.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES - 1;
			m_tready <= 1'b0;
		end else begin
			if (pat_left == 0) begin
				pat_mode = $urandom_range(0, 3);
				pat_left = $urandom_range(20, 200);
			end else begin
				pat_left--;
			end
			case (pat_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= $urandom_range(0, 3) != 0;
				2: m_tready <= $urandom_range(0, 3) == 0;
				default: m_tready <= ~m_tready;
			endcase
		end
	end

	// Watchdog: any transfer on either side counts as progress.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Offers one character and returns at the edge where it is transferred.
	// Characters go out in bursts; between bursts s_tvalid drops for a random
	// gap. Some bursts are long, which gives stretches with no sender gaps.
	task automatic feed_char(input logic [7:0] b);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400) :
				$urandom_range(1, 24);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		burst_left--;
		fed++;
	endtask

	task automatic feed_source();
		foreach (src[i])
			feed_char(src[i]);
		src.delete();
	endtask

	task automatic add_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			src.push_back(s[i]);
	endtask

	// One complete source: the text and the zero byte that ends it.
	task automatic run_source(input string s);
		add_text(s);
		src.push_back(CH_NUL);
		feed_source();
	endtask

	// Stops offering and waits until every predicted token has come out.
	// Waiting on the clock first lets the count of pending tokens catch up with
	// the last transfer.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] rand_letter();
		int r;
		r = $urandom_range(0, 52);
		if (r == 52)
			return "_";
		return (r < 26) ? 8'h61 + 8'(r) : 8'h41 + 8'(r - 26);
	endfunction

	initial begin
		int base;
		int ntok;
		int pick;
		int n;
		int j;
		int m;
		logic held_off;
		logic paused;
		logic [7:0] b;

		held_off = 1'b0;
		paused = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Keywords, near misses and plain identifiers.
		run_source("if else while function return true false iff els functions _Az09 x\n");
		// Every operator, doubled ones, and held characters that stand alone.
		run_source("(){};,+-*/%^ = == != < <= > >= && || ! =a !1 <( >\t/x =&&");
		// Numbers at the edges of the value field, wrap-around, and a number
		// ended directly by an operator.
		run_source("0 2147483647 2147483648 4294967295 4294967296 99999999999 12+7;");
		// Escapes, an unknown escape, a raw newline inside a string, empty string.
		run_source("\"a\\n\\t\\\"\\\\\\q\nz\" \"\" \"x\"y");
		// A string of exactly the maximum length with extreme content bytes.
		src.push_back(CH_QUOTE);
		repeat (STRING_MAX - 2) src.push_back("a");
		src.push_back(8'h01);
		src.push_back(8'hFF);
		src.push_back(CH_QUOTE);
		src.push_back(CH_NUL);
		feed_source();
		// One byte too many: the string is abandoned and the rest dropped.
		src.push_back(CH_QUOTE);
		repeat (STRING_MAX) src.push_back("b");
		run_source("c\" junk 12");
		// Long identifier, keyword with a trailing digit.
		run_source("abcdefghijklmnopqrstuvwxyz0123 function1 whilefalse");
		// Comments, one ended by a newline and one by the end of source.
		run_source("a // hi (\"\nb / c // tail");
		// Errors: lone ampersand, lone bar, bad character, open strings.
		run_source("x &y 1 2");
		run_source("|a (");
		run_source("@ q");
		run_source("\"abc");
		run_source("\"a\\");
		run_source("&");
		run_source("|");
		src.push_back(8'h80);
		run_source(" z");
		src.push_back(8'hFF);
		run_source("");
		src.push_back(8'h01);
		run_source("");
		// Empty source and tokens cut short by the end of source.
		run_source("");
		run_source("12");
		run_source("ab");
		run_source("<");
		run_source("/");
		add_text("< ");
		src.push_back(CH_CR);
		run_source(">= 5");
		// A newline inside a string is not counted as a line.
		run_source("x \"q\nr\" 7 @ 1");
		run_source("\n9");

		drain();

		// Random sources built mostly from well-formed tokens with random
		// content, glued together with or without blanks so that tokens often
		// end each other. Noise bytes, lone '&' and '|', open strings and
		// unterminated comments make up the broken part.
		base = fed;
		while (fed - ignored - base < RANDOM_ITEMS) begin
			if (!held_off && fed - base > 200) begin
				hold_req <= hold_req + 1;
				held_off = 1'b1;
			end
			if (!paused && fed - base > 450) begin
				drain();
				paused = 1'b1;
			end
			ntok = $urandom_range(0, 24);
			for (j = 0; j < ntok; j++) begin
				pick = $urandom_range(0, 99);
				if (pick < 3) begin
					case ($urandom_range(0, 2))
						0: src.push_back(8'($urandom_range(1, 255)));
						1: src.push_back(CH_AMP);
						default: src.push_back(CH_BAR);
					endcase
				end else if (pick < 13) begin
					case ($urandom_range(0, 6))
						0: add_text("if");
						1: add_text("else");
						2: add_text("while");
						3: add_text("function");
						4: add_text("return");
						5: add_text("true");
						default: add_text("false");
					endcase
				end else if (pick < 33) begin
					n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 30) :
						$urandom_range(1, 8);
					src.push_back(rand_letter());
					for (m = 1; m < n; m++)
						src.push_back(($urandom_range(0, 3) == 0) ?
							CH_ZERO + 8'($urandom_range(0, 9)) : rand_letter());
				end else if (pick < 48) begin
					n = $urandom_range(1, 12);
					for (m = 0; m < n; m++)
						src.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
				end else if (pick < 60) begin
					// Rarely a string near or past the length limit.
					n = ($urandom_range(0, 49) == 0) ? $urandom_range(250, 258) :
						$urandom_range(0, 12);
					src.push_back(CH_QUOTE);
					for (m = 0; m < n; m++) begin
						case ($urandom_range(0, 9))
							0: begin
								src.push_back(CH_BSL);
								case ($urandom_range(0, 4))
									0: src.push_back(CH_n);
									1: src.push_back(CH_t);
									2: src.push_back(CH_QUOTE);
									3: src.push_back(CH_BSL);
									default: src.push_back(8'($urandom_range(1, 255)));
								endcase
							end
							1: src.push_back(CH_LF);
							2: src.push_back(8'($urandom_range(128, 255)));
							default: begin
								b = 8'($urandom_range(32, 126));
								src.push_back((b == CH_QUOTE || b == CH_BSL) ? "a" : b);
							end
						endcase
					end
					if ($urandom_range(0, 14) != 0)
						src.push_back(CH_QUOTE);
				end else if (pick < 66) begin
					add_text("//");
					n = $urandom_range(0, 10);
					for (m = 0; m < n; m++) begin
						b = 8'($urandom_range(1, 255));
						src.push_back((b == CH_LF) ? "c" : b);
					end
					if ($urandom_range(0, 9) != 0)
						src.push_back(CH_LF);
				end else begin
					case ($urandom_range(0, 21))
						0: add_text("(");
						1: add_text(")");
						2: add_text("{");
						3: add_text("}");
						4: add_text(";");
						5: add_text(",");
						6: add_text("+");
						7: add_text("-");
						8: add_text("*");
						9: add_text("/");
						10: add_text("%");
						11: add_text("^");
						12: add_text("=");
						13: add_text("==");
						14: add_text("!=");
						15: add_text("<");
						16: add_text("<=");
						17: add_text(">");
						18: add_text(">=");
						19: add_text("&&");
						20: add_text("||");
						default: add_text("!");
					endcase
				end
				if ($urandom_range(0, 9) < 6) begin
					case ($urandom_range(0, 3))
						0: src.push_back(CH_SPACE);
						1: src.push_back(CH_TAB);
						2: src.push_back(CH_CR);
						default: src.push_back(CH_LF);
					endcase
				end
			end
			src.push_back(CH_NUL);
			feed_source();
		end

		// Wait for the last tokens, then keep clocking to catch strays.
		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+design
design/stu_pkg.sv
design/stu_front.sv
design/stu_fifo.sv
design/stu_back.sv
design/script_tokenizer_unit.sv
bench/script_tokenizer_checker.sv
bench/tb_script_tokenizer_unit.sv
